[hdl/aat_pkg.sv]
// Shared types and codes for the login throttle and session table.
`default_nettype none

package aat_pkg;

  // Event actions
  localparam logic [2:0] ACT_CONNECT    = 3'd0;
  localparam logic [2:0] ACT_DISCONNECT = 3'd1;
  localparam logic [2:0] ACT_AUTH       = 3'd2;
  localparam logic [2:0] ACT_IDENTIFY   = 3'd3;
  localparam logic [2:0] ACT_CHECK      = 3'd4;

  // Reply status codes
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_LOCKED       = 4'd1;
  localparam logic [3:0] ST_HASH_MISSING = 4'd2;
  localparam logic [3:0] ST_WRONG_PASS   = 4'd3;
  localparam logic [3:0] ST_NOT_AUTH     = 4'd4;
  localparam logic [3:0] ST_ROLE_REQ     = 4'd5;
  localparam logic [3:0] ST_ROLE_UNKNOWN = 4'd6;
  localparam logic [3:0] ST_DENIED       = 4'd7;
  localparam logic [3:0] ST_CONNECTED    = 4'd8;

  // Client roles
  localparam logic [1:0] ROLE_UNAUTH = 2'd0;
  localparam logic [1:0] ROLE_AUTH   = 2'd1;
  localparam logic [1:0] ROLE_HUB    = 2'd2;

  // Message classes
  localparam logic [1:0] MSG_OPEN      = 2'd0;
  localparam logic [1:0] MSG_PROTECTED = 2'd1;

  // Register indexes
  localparam logic REG_WINDOW       = 1'b0;
  localparam logic REG_MAX_ATTEMPTS = 1'b1;

  localparam logic [31:0] WINDOW_RESET       = 32'd60000;
  localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd5;

  typedef struct packed {
    logic [31:0] window_ms;
    logic [3:0]  max_attempts;
  } aat_cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] now_ms;
  } aat_thr_req_t;

  typedef struct packed {
    logic done;
    logic lockout;
  } aat_thr_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_AUTH,
    S_PUSH
  } aat_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_LOCK,
    T_SCAN,
    T_DECIDE
  } aat_thr_state_t;

endpackage

`default_nettype wire

[hdl/aat_if.sv]
// Request and reply channel interfaces.
`default_nettype none

interface aat_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] client_id;
  logic [31:0] now_ms;
  logic       hash_present;
  logic       hash_match;
  logic       role_present;
  logic       role_is_hub;
  logic [1:0] message_class;

  modport source (
    output valid, action, client_id, now_ms, hash_present, hash_match,
           role_present, role_is_hub, message_class,
    input  ready
  );
  modport sink (
    input  valid, action, client_id, now_ms, hash_present, hash_match,
           role_present, role_is_hub, message_class,
    output ready
  );
endinterface

interface aat_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [1:0] source_type;
  logic       lockout_flag;

  modport source (output valid, status, source_type, lockout_flag, input ready);
  modport sink (input valid, status, source_type, lockout_flag, output ready);
endinterface

`default_nettype wire

[hdl/aat_cfg_regs.sv]
// APB register block: attempt window and attempt limit.
`default_nettype none

module aat_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output aat_pkg::aat_cfg_t cfg
);

  logic [31:0] window_r;
  logic [3:0]  max_att_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= aat_pkg::WINDOW_RESET;
      max_att_r <= aat_pkg::MAX_ATTEMPTS_RESET;
    end else if (wr_en) begin
      if (paddr[2] == aat_pkg::REG_WINDOW) begin
        window_r <= pwdata;
      end else begin
        max_att_r <= pwdata[3:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == aat_pkg::REG_MAX_ATTEMPTS) begin
      prdata = {28'd0, max_att_r};
    end else begin
      prdata = window_r;
    end
  end

  assign cfg.window_ms    = window_r;
  assign cfg.max_attempts = max_att_r;

endmodule

`default_nettype wire

[hdl/aat_age_cmp.sv]
// Shared age compare: is a stamp still inside the window (mod 2^32)?
`default_nettype none

module aat_age_cmp (
  input  wire logic [31:0] now_ms,
  input  wire logic [31:0] stamp,
  input  wire logic [31:0] window_ms,
  output logic             in_window
);

  logic [31:0] age;

  // Wrap-around age, then one compare
  assign age       = now_ms - stamp;
  assign in_window = age < window_ms;

endmodule

`default_nettype wire

[hdl/aat_throttle.sv]
// Attempt throttle: lockout check, stamp scan with compaction, limit decision.
`default_nettype none

module aat_throttle #(
  parameter int unsigned ATTEMPT_SLOTS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire aat_pkg::aat_thr_req_t req,
  input  wire aat_pkg::aat_cfg_t     cfg,
  output aat_pkg::aat_thr_rsp_t      rsp
);

  localparam int unsigned CW = $clog2(ATTEMPT_SLOTS + 1);
  localparam int unsigned IW = (ATTEMPT_SLOTS > 1) ? $clog2(ATTEMPT_SLOTS) : 1;
  localparam int unsigned LW = (CW > 4) ? CW : 4;

  aat_pkg::aat_thr_state_t state_r, state_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [31:0]   stamp_r [ATTEMPT_SLOTS];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic          locked_r, locked_nxt;
  logic [31:0]   lock_start_r, lock_start_nxt;

  logic          stamp_we;
  logic [IW-1:0] stamp_wa;
  logic [31:0]   stamp_wd;
  logic [31:0]   cmp_b;
  logic          in_window;
  logic [LW-1:0] limit;

  // Operand select for the shared compare
  assign cmp_b = (state_r == aat_pkg::T_LOCK) ? lock_start_r : stamp_r[idx_r[IW-1:0]];

  aat_age_cmp u_cmp (
    .now_ms    (now_r),
    .stamp     (cmp_b),
    .window_ms (cfg.window_ms),
    .in_window (in_window)
  );

  // Saturate the limit at the slot count
  assign limit = (LW'(cfg.max_attempts) > LW'(ATTEMPT_SLOTS)) ?
                 LW'(ATTEMPT_SLOTS) : LW'(cfg.max_attempts);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aat_pkg::T_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      kept_r       <= '0;
      locked_r     <= 1'b0;
      lock_start_r <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      kept_r       <= kept_nxt;
      locked_r     <= locked_nxt;
      lock_start_r <= lock_start_nxt;
    end
  end

  // Stamp store and latched time
  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (stamp_we) begin
      stamp_r[stamp_wa] <= stamp_wd;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    kept_nxt       = kept_r;
    locked_nxt     = locked_r;
    lock_start_nxt = lock_start_r;
    stamp_we       = 1'b0;
    stamp_wa       = kept_r[IW-1:0];
    stamp_wd       = cmp_b;
    rsp            = '0;
    case (state_r)
      aat_pkg::T_IDLE: begin
        if (req.start) begin
          now_nxt   = req.now_ms;
          state_nxt = aat_pkg::T_LOCK;
        end
      end
      aat_pkg::T_LOCK: begin
        idx_nxt  = '0;
        kept_nxt = '0;
        if (locked_r && in_window) begin
          rsp.done    = 1'b1;
          rsp.lockout = 1'b1;
          state_nxt   = aat_pkg::T_IDLE;
        end else begin
          // Expired lockout: drop the whole list
          if (locked_r) begin
            locked_nxt = 1'b0;
            cnt_nxt    = '0;
          end
          state_nxt = aat_pkg::T_SCAN;
        end
      end
      aat_pkg::T_SCAN: begin
        if (idx_r == cnt_r) begin
          cnt_nxt   = kept_r;
          state_nxt = aat_pkg::T_DECIDE;
        end else begin
          // Keep a fresh stamp, move it down over dropped ones
          if (in_window) begin
            stamp_we = 1'b1;
            kept_nxt = kept_r + CW'(1);
          end
          idx_nxt = idx_r + CW'(1);
        end
      end
      aat_pkg::T_DECIDE: begin
        rsp.done  = 1'b1;
        state_nxt = aat_pkg::T_IDLE;
        if (LW'(cnt_r) >= limit) begin
          locked_nxt     = 1'b1;
          lock_start_nxt = now_r;
          rsp.lockout    = 1'b1;
        end else begin
          stamp_we = 1'b1;
          stamp_wa = cnt_r[IW-1:0];
          stamp_wd = now_r;
          cnt_nxt  = cnt_r + CW'(1);
        end
      end
      default: begin
        state_nxt = aat_pkg::T_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/auth_attempt_throttle_sessions_top.sv]
// Top level: request capture, session table, dispatch and reply register.
//
//   channel   dir  handshake               payload
//   in_ch     in   valid/ready             action, client_id, now_ms, hash/role bits, class
//   out_ch    out  valid/ready             status, source_type, lockout_flag
//   APB       in   psel/penable/pwrite     paddr (3 bits), pwdata/prdata (32 bits)
//
// Non-auth requests pass EXEC and PUSH, then load the reply register; a
// disconnect gives none. Auth requests add AUTH: the throttle scans stored
// attempts one per cycle via the shared age compare, unless locked out.
// Reset is synchronous (rst_n low); it clears the table and the throttle.
// The next request is taken while a reply waits in the output register;
// a reply stalls in place until that register frees up.
`default_nettype none

module auth_attempt_throttle_sessions_top #(
  parameter int unsigned ATTEMPT_SLOTS = 8,
  parameter int unsigned CLIENT_SLOTS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  aat_in_if.sink           in_ch,
  aat_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CIW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;

  aat_pkg::aat_cfg_t     cfg;
  aat_pkg::aat_thr_req_t thr_req;
  aat_pkg::aat_thr_rsp_t thr_rsp;

  aat_pkg::aat_state_t state_r, state_nxt;

  // Captured request
  logic [2:0]  act_r;
  logic [7:0]  id_r;
  logic [31:0] now_r;
  logic        hpres_r, hmatch_r, rpres_r, rhub_r;
  logic [1:0]  mclass_r;
  logic [3:0]  pend_r, pend_nxt;

  // Session table
  logic        active_r [CLIENT_SLOTS];
  logic        authed_r [CLIENT_SLOTS];
  logic [1:0]  role_r   [CLIENT_SLOTS];

  // Reply register
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_status_r;
  logic [1:0]  out_src_r;
  logic        out_lock_r;

  logic           in_acc;
  logic           out_free;
  logic           out_load;
  logic           in_range;
  logic [CIW-1:0] ci;
  logic [1:0]     role_seen;
  logic           tbl_clr, tbl_clr_val, tbl_auth, tbl_hub;

  aat_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aat_throttle #(.ATTEMPT_SLOTS(ATTEMPT_SLOTS)) u_thr (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (thr_req),
    .cfg   (cfg),
    .rsp   (thr_rsp)
  );

  assign in_ch.ready = (state_r == aat_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Table lookup for the captured client
  assign in_range  = id_r < 8'(CLIENT_SLOTS);
  assign ci        = id_r[CIW-1:0];
  assign role_seen = (in_range && active_r[ci]) ? role_r[ci] : aat_pkg::ROLE_UNAUTH;

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_ch.action;
      id_r     <= in_ch.client_id;
      now_r    <= in_ch.now_ms;
      hpres_r  <= in_ch.hash_present;
      hmatch_r <= in_ch.hash_match;
      rpres_r  <= in_ch.role_present;
      rhub_r   <= in_ch.role_is_hub;
      mclass_r <= in_ch.message_class;
    end
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aat_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Dispatch and table update control
  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    thr_req.start  = 1'b0;
    thr_req.now_ms = now_r;
    tbl_clr        = 1'b0;
    tbl_clr_val    = 1'b0;
    tbl_auth       = 1'b0;
    tbl_hub        = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      aat_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = aat_pkg::S_EXEC;
        end
      end
      aat_pkg::S_EXEC: begin
        state_nxt = aat_pkg::S_PUSH;
        case (act_r)
          aat_pkg::ACT_CONNECT: begin
            tbl_clr     = 1'b1;
            tbl_clr_val = 1'b1;
            pend_nxt    = aat_pkg::ST_CONNECTED;
          end
          aat_pkg::ACT_DISCONNECT: begin
            tbl_clr   = 1'b1;
            state_nxt = aat_pkg::S_IDLE;
          end
          aat_pkg::ACT_AUTH: begin
            thr_req.start = 1'b1;
            state_nxt     = aat_pkg::S_AUTH;
          end
          aat_pkg::ACT_IDENTIFY: begin
            if (!in_range || !authed_r[ci]) begin
              pend_nxt = aat_pkg::ST_NOT_AUTH;
            end else if (!rpres_r) begin
              pend_nxt = aat_pkg::ST_ROLE_REQ;
            end else if (!rhub_r) begin
              pend_nxt = aat_pkg::ST_ROLE_UNKNOWN;
            end else begin
              tbl_hub  = 1'b1;
              pend_nxt = aat_pkg::ST_OK;
            end
          end
          aat_pkg::ACT_CHECK: begin
            if (mclass_r == aat_pkg::MSG_OPEN) begin
              pend_nxt = aat_pkg::ST_OK;
            end else if (mclass_r == aat_pkg::MSG_PROTECTED &&
                         role_seen != aat_pkg::ROLE_UNAUTH) begin
              pend_nxt = aat_pkg::ST_OK;
            end else begin
              pend_nxt = aat_pkg::ST_DENIED;
            end
          end
          default: begin
            state_nxt = aat_pkg::S_IDLE;
          end
        endcase
      end
      aat_pkg::S_AUTH: begin
        if (thr_rsp.done) begin
          state_nxt = aat_pkg::S_PUSH;
          if (thr_rsp.lockout) begin
            pend_nxt = aat_pkg::ST_LOCKED;
          end else if (!hpres_r) begin
            pend_nxt = aat_pkg::ST_HASH_MISSING;
          end else if (!hmatch_r) begin
            pend_nxt = aat_pkg::ST_WRONG_PASS;
          end else begin
            tbl_auth = 1'b1;
            pend_nxt = aat_pkg::ST_OK;
          end
        end
      end
      aat_pkg::S_PUSH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = aat_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = aat_pkg::S_IDLE;
      end
    endcase
  end

  // Session table: only ids in range touch it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CLIENT_SLOTS; k++) begin
        active_r[k] <= 1'b0;
        authed_r[k] <= 1'b0;
        role_r[k]   <= aat_pkg::ROLE_UNAUTH;
      end
    end else if (in_range) begin
      if (tbl_clr) begin
        active_r[ci] <= tbl_clr_val;
        authed_r[ci] <= 1'b0;
        role_r[ci]   <= aat_pkg::ROLE_UNAUTH;
      end else if (tbl_auth) begin
        authed_r[ci] <= 1'b1;
        role_r[ci]   <= aat_pkg::ROLE_AUTH;
      end else if (tbl_hub) begin
        role_r[ci] <= aat_pkg::ROLE_HUB;
      end
    end
  end

  // Reply register: load on push, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= pend_r;
      out_src_r    <= role_seen;
      out_lock_r   <= (pend_r == aat_pkg::ST_LOCKED);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.source_type  = out_src_r;
  assign out_ch.lockout_flag = out_lock_r;

  // Checks
  a_thr_done_in_auth: assert property (@(posedge clk) disable iff (!rst_n)
    thr_rsp.done |-> state_r == aat_pkg::S_AUTH)
    else $error("throttle finished outside an auth request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request taken while previous one still in progress");

  a_push_loads_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aat_pkg::S_PUSH && out_free) |=> out_ch.valid)
    else $error("pending reply lost at push");

  a_lock_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.lockout_flag == (out_ch.status == aat_pkg::ST_LOCKED)))
    else $error("lockout flag disagrees with status");

endmodule

`default_nettype wire
